>>> hdl/ezr_pkg.sv
// ----------------------------------------------------------------------------
// ezr_pkg: shared types, constants and tables of the ZYZ Euler vector rotator
// Fixed-point widths, CORDIC arctangent table, result types.
// ----------------------------------------------------------------------------
package ezr_pkg;

  localparam int DataWidth      = 32;
  localparam int CordicSteps    = 24;
  localparam int MaxCordicSteps = 40;
  localparam int AngleWidth     = 26;
  localparam int FracBits       = 30;

  // Q16.16 degree constants
  localparam logic signed [AngleWidth+1:0] TurnDeg        = 28'sd23592960;
  localparam logic signed [AngleWidth+1:0] HalfTurnDeg    = 28'sd11796480;
  localparam logic signed [AngleWidth+1:0] QuarterTurnDeg = 28'sd5898240;

  localparam logic signed [63:0] OneQ30  = 64'sd1073741824;
  localparam logic signed [63:0] HalfQ30 = 64'sd536870912;
  localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;
  localparam logic signed [63:0] GainQ60 = 64'sh26DD3B6A << 30;
  // pi/180 in Q40
  localparam logic [63:0] Deg2Rad = ((PiQ60 / 180) + (64'd1 << 19)) >> 20;

  // arctan(2^-i) in Q56
  function automatic logic signed [63:0] atan_q56(input int i);
    logic [63:0] acc;
    logic [63:0] t;
    int k;
    acc = '0;
    if (i == 0) begin
      acc = PiQ60;
    end else begin
      for (k = 0; k < 32; k++) begin
        if (i * (2 * k + 1) <= 62) begin
          t = ((64'd1 << 62) >> (i * (2 * k + 1))) / 64'(2 * k + 1);
          if (k % 2 == 1) acc = acc - t;
          else acc = acc + t;
        end
      end
    end
    return $signed((acc + 64'd32) >> 6);
  endfunction

  function automatic logic signed [63:0] clamp_one(input logic signed [63:0] v);
    if (v > OneQ30) return OneQ30;
    if (v < -OneQ30) return -OneQ30;
    return v;
  endfunction

  // rounded Q30 product of two values in [-1, 1]
  function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + HalfQ30;
    return 32'(p >>> FracBits);
  endfunction

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } sincos_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

endpackage

>>> hdl/ezr_if.sv
// ----------------------------------------------------------------------------
// ezr_in_if / ezr_out_if: valid/ready channels of the rotator
// One item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ezr_in_if;
  logic valid;
  logic ready;
  logic signed [25:0] phi_deg;
  logic signed [31:0] cos_theta;
  logic signed [25:0] psi_deg;
  logic signed [31:0] par_in_x;
  logic signed [31:0] par_in_y;
  logic signed [31:0] par_in_z;
  logic signed [31:0] perp_in_x;
  logic signed [31:0] perp_in_y;
  logic signed [31:0] perp_in_z;
  logic signed [31:0] dir_in_x;
  logic signed [31:0] dir_in_y;
  logic signed [31:0] dir_in_z;
  modport source (output valid, phi_deg, cos_theta, psi_deg, par_in_x, par_in_y,
                  par_in_z, perp_in_x, perp_in_y, perp_in_z, dir_in_x, dir_in_y,
                  dir_in_z, input ready);
  modport sink (input valid, phi_deg, cos_theta, psi_deg, par_in_x, par_in_y,
                par_in_z, perp_in_x, perp_in_y, perp_in_z, dir_in_x, dir_in_y,
                dir_in_z, output ready);
endinterface

interface ezr_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] par_out_x;
  logic signed [31:0] par_out_y;
  logic signed [31:0] par_out_z;
  logic signed [31:0] perp_out_x;
  logic signed [31:0] perp_out_y;
  logic signed [31:0] perp_out_z;
  logic signed [31:0] dir_out_x;
  logic signed [31:0] dir_out_y;
  logic signed [31:0] dir_out_z;
  modport source (output valid, par_out_x, par_out_y, par_out_z, perp_out_x,
                  perp_out_y, perp_out_z, dir_out_x, dir_out_y, dir_out_z,
                  input ready);
  modport sink (input valid, par_out_x, par_out_y, par_out_z, perp_out_x,
                perp_out_y, perp_out_z, dir_out_x, dir_out_y, dir_out_z,
                output ready);
endinterface

>>> hdl/euler_zyz_vector_rotator.sv
// ----------------------------------------------------------------------------
// euler_zyz_vector_rotator: negative ZYZ Euler rotation of three vectors
// Channel | dir | payload
// in      | sink   | angles, cos(theta), three lab-frame vectors
// out     | source | three target-frame vectors, Q2.30 saturated
// One item per cycle while the output is not stalled; each item passes the
// CORDIC chain or the square root, whichever is deeper, then five rotation
// stages. Whole pipeline advances together; a stall at the output freezes all
// stages, so in.ready drops only while the last stage holds an item that
// out.ready does not take. Reset clears valid bits only.
// ----------------------------------------------------------------------------
module euler_zyz_vector_rotator #(
  parameter int DATA_WIDTH   = ezr_pkg::DataWidth,
  parameter int CORDIC_STEPS = ezr_pkg::CordicSteps
) (
  input logic clk,
  input logic rst,
  ezr_in_if.sink    in,
  ezr_out_if.source out
);

  localparam int CordicLat = CORDIC_STEPS + 3;
  // square stage plus one stage per root bit
  localparam int SqrtLat   = 32;
  localparam int TrigLat   = (CordicLat > SqrtLat) ? CordicLat : SqrtLat;
  localparam int TrigPad   = TrigLat - CordicLat;
  localparam int Lat       = TrigLat + 5;

  // pipeline enable: advance when last stage is empty or consumed
  logic [Lat-1:0] vld;
  logic           en;
  assign en       = !vld[Lat-1] || out.ready;
  assign in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], in.valid};
  end

  ezr_pkg::sincos_t   ph, ps;
  ezr_pkg::sincos_t   ph_raw, ps_raw;
  ezr_pkg::sincos_t   ph_dly [TrigPad+1];
  ezr_pkg::sincos_t   ps_dly [TrigPad+1];
  logic signed [31:0] ct_in, st;
  logic signed [31:0] ct_dly [TrigLat];
  ezr_pkg::vec3_t     v_dly [TrigLat][3];
  ezr_pkg::vec3_t     vout [3];

  always_comb begin
    ct_in = in.cos_theta;
    if (in.cos_theta > 32'sd1073741824) ct_in = 32'sd1073741824;
    else if (in.cos_theta < -32'sd1073741824) ct_in = -32'sd1073741824;
  end

  ezr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_phi (
    .clk(clk), .en(en), .deg(in.phi_deg), .sc(ph_raw));
  ezr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_psi (
    .clk(clk), .en(en), .deg(in.psi_deg), .sc(ps_raw));
  ezr_sqrt #(.LATENCY(TrigLat)) u_sqrt (
    .clk(clk), .en(en), .ct(ct_in), .st(st));

  // align the CORDIC outputs with the square root when the root is deeper
  assign ph_dly[0] = ph_raw;
  assign ps_dly[0] = ps_raw;
  for (genvar j = 0; j < TrigPad; j++) begin : g_trig_pad
    always_ff @(posedge clk) begin
      if (en) begin
        ph_dly[j+1] <= ph_dly[j];
        ps_dly[j+1] <= ps_dly[j];
      end
    end
  end
  assign ph = ph_dly[TrigPad];
  assign ps = ps_dly[TrigPad];

  always_ff @(posedge clk) begin
    if (en) begin
      ct_dly[0] <= ct_in;
      v_dly[0][0] <= '{in.par_in_x, in.par_in_y, in.par_in_z};
      v_dly[0][1] <= '{in.perp_in_x, in.perp_in_y, in.perp_in_z};
      v_dly[0][2] <= '{in.dir_in_x, in.dir_in_y, in.dir_in_z};
      for (int k = 1; k < TrigLat; k++) begin
        ct_dly[k] <= ct_dly[k-1];
        v_dly[k]  <= v_dly[k-1];
      end
    end
  end

  ezr_rotate #(.DATA_WIDTH(DATA_WIDTH)) u_rot (
    .clk(clk), .en(en), .ph(ph), .ps(ps), .ct(ct_dly[TrigLat-1]), .st(st),
    .vin(v_dly[TrigLat-1]), .vout(vout));

  assign out.valid      = vld[Lat-1];
  assign out.par_out_x  = vout[0].x;
  assign out.par_out_y  = vout[0].y;
  assign out.par_out_z  = vout[0].z;
  assign out.perp_out_x = vout[1].x;
  assign out.perp_out_y = vout[1].y;
  assign out.perp_out_z = vout[1].z;
  assign out.dir_out_x  = vout[2].x;
  assign out.dir_out_y  = vout[2].y;
  assign out.dir_out_z  = vout[2].z;

endmodule

>>> hdl/ezr_cordic.sv
// ----------------------------------------------------------------------------
// ezr_cordic: pipelined sine/cosine of a degree angle
// One fold stage, one scale stage, one stage per CORDIC step, one rounding
// stage.
// ----------------------------------------------------------------------------
module ezr_cordic #(
  parameter int CORDIC_STEPS = ezr_pkg::CordicSteps
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [25:0]    deg,
  output ezr_pkg::sincos_t      sc
);

  localparam int Lat = CORDIC_STEPS + 2;

  logic signed [27:0] d0, d1;
  logic               fold;
  logic signed [27:0] dred;
  logic signed [27:0] dred_q;
  logic               fold_q;

  always_comb begin
    d0 = 28'(deg);
    if (d0 >= ezr_pkg::HalfTurnDeg) d1 = d0 - ezr_pkg::TurnDeg;
    else if (d0 < -ezr_pkg::HalfTurnDeg) d1 = d0 + ezr_pkg::TurnDeg;
    else d1 = d0;
    fold = 1'b0;
    dred = d1;
    if (d1 > ezr_pkg::QuarterTurnDeg) begin
      dred = d1 - ezr_pkg::HalfTurnDeg;
      fold = 1'b1;
    end else if (d1 < -ezr_pkg::QuarterTurnDeg) begin
      dred = d1 + ezr_pkg::HalfTurnDeg;
      fold = 1'b1;
    end
  end

  // wrapped and folded angle, registered ahead of the scaling multiply
  always_ff @(posedge clk) begin
    if (en) begin
      dred_q <= dred;
      fold_q <= fold;
    end
  end

  logic signed [63:0] xs [CORDIC_STEPS+1];
  logic signed [63:0] ys [CORDIC_STEPS+1];
  logic signed [63:0] zs [CORDIC_STEPS+1];
  logic [Lat-1:0]     neg;

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= ezr_pkg::GainQ60;
      ys[0] <= '0;
      zs[0] <= 64'(dred_q) * $signed(ezr_pkg::Deg2Rad);
      neg   <= {neg[Lat-2:0], fold_q};
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [63:0] Atan = ezr_pkg::atan_q56(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - Atan;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + Atan;
        end
      end
    end
  end

  logic signed [63:0] c, s;
  always_comb begin
    c = ezr_pkg::clamp_one((xs[CORDIC_STEPS] + ezr_pkg::HalfQ30) >>> ezr_pkg::FracBits);
    s = ezr_pkg::clamp_one((ys[CORDIC_STEPS] + ezr_pkg::HalfQ30) >>> ezr_pkg::FracBits);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc.c <= neg[Lat-2] ? -32'(c) : 32'(c);
      sc.s <= neg[Lat-2] ? -32'(s) : 32'(s);
    end
  end

endmodule

>>> hdl/ezr_sqrt.sv
// ----------------------------------------------------------------------------
// ezr_sqrt: pipelined sin(theta) = floor(sqrt(1 - ct^2)) in Q30
// One square stage, one stage per root bit, then a delay up to LATENCY if deeper.
// ----------------------------------------------------------------------------
module ezr_sqrt #(
  parameter int LATENCY = 26
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] ct,
  output logic signed [31:0] st
);

  localparam int Bits = 31;

  logic [63:0] rem [Bits+1];
  logic [63:0] root [Bits+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= 64'(ezr_pkg::OneQ30 * ezr_pkg::OneQ30) - 64'(64'(ct) * 64'(ct));
      root[0] <= '0;
    end
  end

  // restoring root, one bit per stage, bit positions 2*(30-i)
  for (genvar i = 0; i < Bits; i++) begin : g_bit
    localparam logic [63:0] Bit = 64'd1 << (2 * (Bits - 1 - i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[i] >= root[i] + Bit) begin
          rem[i+1]  <= rem[i] - (root[i] + Bit);
          root[i+1] <= (root[i] >> 1) + Bit;
        end else begin
          rem[i+1]  <= rem[i];
          root[i+1] <= root[i] >> 1;
        end
      end
    end
  end

  // delay to the common latency (Bits+1 <= LATENCY assumed, else the root passes undelayed)
  localparam int Pad = (LATENCY > Bits + 1) ? LATENCY - Bits - 1 : 1;
  logic [31:0] dly [Pad+1];
  assign dly[0] = 32'(root[Bits]);
  for (genvar j = 0; j < Pad; j++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) dly[j+1] <= dly[j];
    end
  end
  assign st = (LATENCY > Bits + 1) ? $signed(dly[Pad]) : $signed(dly[0]);

endmodule

>>> hdl/ezr_rotate.sv
// ----------------------------------------------------------------------------
// ezr_rotate: matrix build and vector rotation pipeline
// Stage A pairs products, stage B triple products, stage C entries,
// stage D component products, stage E sums and saturation.
// ----------------------------------------------------------------------------
module ezr_rotate #(
  parameter int DATA_WIDTH = ezr_pkg::DataWidth
) (
  input  logic               clk,
  input  logic               en,
  input  ezr_pkg::sincos_t   ph,
  input  ezr_pkg::sincos_t   ps,
  input  logic signed [31:0] ct,
  input  logic signed [31:0] st,
  input  ezr_pkg::vec3_t     vin [3],
  output ezr_pkg::vec3_t     vout [3]
);

  // stage A
  logic signed [31:0] a_cpct, a_spct, a_spss, a_cpss, a_spcs, a_cpcs, a_stcs, a_stss;
  logic signed [31:0] a_cpst, a_spst, a_ct, a_cs, a_ss;
  ezr_pkg::vec3_t     a_v [3], b_v [3], c_v [3];

  always_ff @(posedge clk) begin
    if (en) begin
      a_cpct <= ezr_pkg::mul30(ph.c, ct);
      a_spct <= ezr_pkg::mul30(ph.s, ct);
      a_spss <= ezr_pkg::mul30(ph.s, ps.s);
      a_cpss <= ezr_pkg::mul30(ph.c, ps.s);
      a_spcs <= ezr_pkg::mul30(ph.s, ps.c);
      a_cpcs <= ezr_pkg::mul30(ph.c, ps.c);
      a_stcs <= ezr_pkg::mul30(st, ps.c);
      a_stss <= ezr_pkg::mul30(st, ps.s);
      a_cpst <= ezr_pkg::mul30(ph.c, st);
      a_spst <= ezr_pkg::mul30(ph.s, st);
      a_ct <= ct;
      a_cs <= ps.c;
      a_ss <= ps.s;
      a_v  <= vin;
    end
  end

  // stage B: triple products and raw entries
  logic signed [33:0] m [9];
  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= 34'(ezr_pkg::mul30(a_cpct, a_cs)) - 34'(a_spss);
      m[1] <= 34'(ezr_pkg::mul30(a_spct, a_cs)) + 34'(a_cpss);
      m[2] <= -34'(a_stcs);
      m[3] <= -34'(ezr_pkg::mul30(a_cpct, a_ss)) - 34'(a_spcs);
      m[4] <= -34'(ezr_pkg::mul30(a_spct, a_ss)) + 34'(a_cpcs);
      m[5] <= 34'(a_stss);
      m[6] <= 34'(a_cpst);
      m[7] <= 34'(a_spst);
      m[8] <= 34'(a_ct);
      b_v  <= a_v;
    end
  end

  // stage C: clamp entries
  logic signed [31:0] mc [9];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 9; j++) mc[j] <= 32'(ezr_pkg::clamp_one(64'(m[j])));
      c_v <= b_v;
    end
  end

  // stage D: 27 products
  logic signed [63:0] p [3][3][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        for (int r = 0; r < 3; r++) begin
          p[v][r][0] <= 64'(c_v[v].x) * 64'(mc[r*3]);
          p[v][r][1] <= 64'(c_v[v].y) * 64'(mc[r*3+1]);
          p[v][r][2] <= 64'(c_v[v].z) * 64'(mc[r*3+2]);
        end
      end
    end
  end

  // stage E: sum, round, saturate
  localparam logic signed [65:0] Hi = 66'((67'sd1 <<< (DATA_WIDTH - 1)) - 1);
  localparam logic signed [65:0] Lo = -Hi - 66'sd1;
  logic signed [31:0] res [3][3];
  always_comb begin
    logic signed [65:0] acc;
    for (int v = 0; v < 3; v++) begin
      for (int r = 0; r < 3; r++) begin
        acc = 66'(p[v][r][0]) + 66'(p[v][r][1]) + 66'(p[v][r][2]) + 66'(ezr_pkg::HalfQ30);
        acc = acc >>> ezr_pkg::FracBits;
        if (acc > Hi) acc = Hi;
        else if (acc < Lo) acc = Lo;
        res[v][r] = 32'(acc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        vout[v].x <= res[v][0];
        vout[v].y <= res[v][1];
        vout[v].z <= res[v][2];
      end
    end
  end

endmodule

>>> bench/tb_euler_zyz_vector_rotator.sv
// ----------------------------------------------------------------------------
// tb_euler_zyz_vector_rotator: self-checking bench of the ZYZ Euler rotator
// A directed table of corner items, then random items under three idle
// patterns. Each accepted item is predicted in fixed point and compared,
// component by component, with the matching result in order.
// ----------------------------------------------------------------------------
module tb_euler_zyz_vector_rotator;

  localparam int NumRandom = 450;
  localparam int Steps     = ezr_pkg::CordicSteps;

  typedef struct packed {
    logic signed [25:0] phi;
    logic signed [31:0] ct;
    logic signed [25:0] psi;
    logic [8:0][31:0]   comp;  // par xyz, perp xyz, dir xyz
  } rot_item_t;

  typedef logic [8:0][31:0] rot_res_t;

  logic clk;
  logic rst;
  ezr_in_if  inb();
  ezr_out_if outb();

  euler_zyz_vector_rotator dut (.clk(clk), .rst(rst), .in(inb), .out(outb));

  rot_res_t rotated_q[$];
  longint   atan_tab[Steps];
  int       errors;
  int       tx_idle;
  int       rx_idle;
  bit       hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 600000);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(int idx, logic [31:0] got, logic [31:0] want);
    $display("mismatch comp %0d: got %h want %h", idx, got, want);
    errors++;
  endtask

  function automatic void build_atan_tab();
    longint unsigned acc, t;
    for (int i = 0; i < Steps; i++) begin
      acc = 0;
      if (i == 0) acc = ezr_pkg::PiQ60;
      else begin
        for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
          t = ((64'd1 << 62) >> (i * (2 * k + 1))) / longint'(2 * k + 1);
          if (k % 2 == 1) acc = acc - t;
          else acc = acc + t;
        end
      end
      atan_tab[i] = longint'((acc + 64'd32) >> 6);
    end
  endfunction

  function automatic longint clamp1(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint rmul(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic void deg_sincos(longint d, output longint co, output longint si);
    longint unsigned pi_q60, d2r_u;
    longint d2r, x, y, z, dx, dy;
    bit     flip;
    pi_q60 = 64'h3243F6A8885A308D;
    d2r_u = ((pi_q60 / 64'd180) + (64'd1 << 19)) >> 20;
    d2r = longint'(d2r_u);
    x = 64'sh26DD3B6A <<< 30;
    y = 0;
    flip = 1'b0;
    while (d >= 11796480) d -= 23592960;
    while (d < -11796480) d += 23592960;
    if (d > 5898240) begin
      d -= 11796480;
      flip = 1'b1;
    end else if (d < -5898240) begin
      d += 11796480;
      flip = 1'b1;
    end
    z = d * d2r;
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    co = clamp1((x + 64'sd536870912) >>> 30);
    si = clamp1((y + 64'sd536870912) >>> 30);
    if (flip) begin
      co = -co;
      si = -si;
    end
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic rot_res_t rotate_vectors(rot_item_t it);
    longint cp, sp, cs, ss, ct, st, acc, res;
    longint m[9];
    longint v[9];
    rot_res_t out_v;
    deg_sincos(longint'(it.phi), cp, sp);
    deg_sincos(longint'(it.psi), cs, ss);
    ct = clamp1(longint'(it.ct));
    st = longint'(int_sqrt(64'd1152921504606846976 - longint'(ct * ct)));
    m[0] = rmul(rmul(cp, ct), cs) - rmul(sp, ss);
    m[1] = rmul(rmul(sp, ct), cs) + rmul(cp, ss);
    m[2] = -rmul(st, cs);
    m[3] = -rmul(rmul(cp, ct), ss) - rmul(sp, cs);
    m[4] = -rmul(rmul(sp, ct), ss) + rmul(cp, cs);
    m[5] = rmul(st, ss);
    m[6] = rmul(cp, st);
    m[7] = rmul(sp, st);
    m[8] = ct;
    for (int j = 0; j < 9; j++) begin
      m[j] = clamp1(m[j]);
      v[j] = longint'($signed(it.comp[j]));
    end
    for (int r = 0; r < 9; r++) begin
      acc = v[(r / 3) * 3] * m[(r % 3) * 3] + v[(r / 3) * 3 + 1] * m[(r % 3) * 3 + 1]
          + v[(r / 3) * 3 + 2] * m[(r % 3) * 3 + 2];
      res = (acc + 64'sd536870912) >>> 30;
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      out_v[r] = res[31:0];
    end
    return out_v;
  endfunction

  // drive one item at a falling edge, hold it until accepted
  task automatic send_item(rot_item_t it, bit typed, rot_res_t want);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      inb.valid = 1'b0;
      @(negedge clk);
    end
    inb.phi_deg   = it.phi;
    inb.cos_theta = it.ct;
    inb.psi_deg   = it.psi;
    inb.par_in_x  = it.comp[0];
    inb.par_in_y  = it.comp[1];
    inb.par_in_z  = it.comp[2];
    inb.perp_in_x = it.comp[3];
    inb.perp_in_y = it.comp[4];
    inb.perp_in_z = it.comp[5];
    inb.dir_in_x  = it.comp[6];
    inb.dir_in_y  = it.comp[7];
    inb.dir_in_z  = it.comp[8];
    inb.valid     = 1'b1;
    do @(posedge clk); while (!inb.ready);
    rotated_q.push_back(typed ? want : rotate_vectors(it));
  endtask

  function automatic logic [25:0] rand_angle();
    case ($urandom_range(3))
      0: return 26'($urandom);
      1: return 26'($urandom_range(23592960) - 11796480);
      2: return 26'(($urandom_range(1) ? 5898240 : 11796480) * ($urandom_range(1) ? 1 : -1)
                    + $urandom_range(4) - 2);
      default: return 26'($urandom_range(11796480) - 5898240);
    endcase
  endfunction

  function automatic rot_item_t rand_item();
    rot_item_t it;
    it.phi = rand_angle();
    it.psi = rand_angle();
    if ($urandom_range(9) < 2) it.ct = $urandom;
    else it.ct = 32'(longint'($urandom_range(32'h8000_0000)) - 64'sd1073741824);
    for (int j = 0; j < 9; j++) begin
      if ($urandom_range(1)) it.comp[j] = $urandom;
      else it.comp[j] = 32'(longint'($urandom_range(32'h8000_0000)) - 64'sd1073741824);
    end
    return it;
  endfunction

  function automatic rot_item_t mk(logic [25:0] phi, logic [31:0] ct, logic [25:0] psi,
                                   logic [31:0] a, logic [31:0] b);
    rot_item_t it;
    it.phi = phi;
    it.ct  = ct;
    it.psi = psi;
    for (int j = 0; j < 9; j++) it.comp[j] = (j % 2 == 0) ? a : b;
    return it;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    outb.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        outb.ready = 1'b0;
        for (int n = 0; n < 150; n++) @(negedge clk);
        hold_req = 1'b0;
      end
      outb.ready = ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    rot_res_t got, want;
    if (!rst && outb.valid && outb.ready) begin
      got = {outb.dir_out_z, outb.dir_out_y, outb.dir_out_x,
             outb.perp_out_z, outb.perp_out_y, outb.perp_out_x,
             outb.par_out_z, outb.par_out_y, outb.par_out_x};
      if (rotated_q.size() == 0) begin
        $display("result with no item pending");
        errors++;
      end else begin
        want = rotated_q.pop_front();
        for (int j = 0; j < 9; j++)
          if (got[j] !== want[j]) report_mismatch(j, got[j], want[j]);
      end
    end
  end

  initial begin
    rot_item_t dir_tab[18];
    bit        typed_tab[18];
    rot_res_t  zero_res;
    int        waited;
    errors = 0;
    tx_idle = 32;
    rx_idle = 88;
    hold_req = 1'b0;
    zero_res = '0;
    rst = 1'b1;
    inb.valid = 1'b0;
    inb.phi_deg = '0;
    inb.cos_theta = '0;
    inb.psi_deg = '0;
    inb.par_in_x = '0;
    inb.par_in_y = '0;
    inb.par_in_z = '0;
    inb.perp_in_x = '0;
    inb.perp_in_y = '0;
    inb.perp_in_z = '0;
    inb.dir_in_x = '0;
    inb.dir_in_y = '0;
    inb.dir_in_z = '0;
    build_atan_tab();
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // corner angles, cosine limits, extreme components; zero vectors rotate to zero
    dir_tab[0]  = mk(26'd0, 32'h4000_0000, 26'd0, 32'h4000_0000, 32'h0);
    dir_tab[1]  = mk(26'd11796480, 32'h0, -26'sd11796480, 32'h4000_0000, 32'hC000_0000);
    dir_tab[2]  = mk(26'd5898240, 32'hC000_0000, -26'sd5898240, 32'h1234_5678, 32'h8765_4321);
    dir_tab[3]  = mk(26'h1FF_FFFF, 32'h7FFF_FFFF, 26'h200_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    dir_tab[4]  = mk(26'h200_0000, 32'h8000_0000, 26'h1FF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    dir_tab[5]  = mk(26'd5898241, 32'h4000_0001, 26'd5898239, 32'hFFFF_FFFF, 32'h0000_0001);
    dir_tab[6]  = mk(-26'sd5898241, 32'hBFFF_FFFF, 26'd11796479, 32'h4000_0000, 32'h4000_0000);
    dir_tab[7]  = mk(26'd23592960, 32'h2D41_3CCD, -26'sd23592960, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    dir_tab[8]  = mk(26'd2949120, 32'h0000_0001, 26'd8847360, 32'h8000_0000, 32'h8000_0000);
    dir_tab[9]  = mk(-26'sd11796481, 32'hFFFF_FFFF, 26'd1, 32'h2AAA_AAAA, 32'hD555_5556);
    dir_tab[10] = mk(26'h1FF_FFFF, 32'h7FFF_FFFF, 26'h200_0000, 32'h0, 32'h0);
    dir_tab[11] = mk(26'd11796480, 32'h8000_0000, 26'd5898240, 32'h0, 32'h0);
    dir_tab[12] = mk(-26'sd5898240, 32'h0, 26'd0, 32'h0, 32'h0);
    dir_tab[13] = mk(26'd65536, 32'h3FFF_FFFF, 26'd65536, 32'h4000_0000, 32'hC000_0000);
    dir_tab[14] = mk(26'd17694720, 32'hC000_0001, -26'sd17694720, 32'h5A82_799A, 32'hA57D_8666);
    dir_tab[15] = mk(26'h155_5555, 32'h5555_5555, 26'h2AA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    dir_tab[16] = mk(26'h2AA_AAAA, 32'hAAAA_AAAA, 26'h155_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    dir_tab[17] = mk(26'd0, 32'h4000_0000, 26'd0, 32'h0, 32'h0);
    for (int r = 0; r < 18; r++) typed_tab[r] = (dir_tab[r].comp == '0);
    for (int r = 0; r < 18; r++) send_item(dir_tab[r], typed_tab[r], zero_res);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 150) begin
        tx_idle = 88;
        rx_idle = 32;
      end
      if (n == 300) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      if (n == 60) hold_req = 1'b1;
      if (n == 200) begin
        @(negedge clk);
        inb.valid = 1'b0;
        wait (rotated_q.size() == 0);
      end
      send_item(rand_item(), 1'b0, zero_res);
    end
    @(negedge clk);
    inb.valid = 1'b0;

    waited = 0;
    while (rotated_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (ezr_pkg::CordicSteps + 20) @(posedge clk);
    if (errors == 0 && rotated_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/ezr_pkg.sv
hdl/ezr_if.sv
hdl/ezr_cordic.sv
hdl/ezr_sqrt.sv
hdl/ezr_rotate.sv
hdl/euler_zyz_vector_rotator.sv
bench/tb_euler_zyz_vector_rotator.sv
